// ----- hdl/raftjq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raftjq_pkg
// shared constants, types and helpers of the joint quorum commit tracker
// ----------------------------------------------------------------------------
package raftjq_pkg;

    localparam int NODES    = 16;
    localparam int VAL_W    = 64;
    localparam int PLANE_AW = $clog2(VAL_W);
    localparam int SLOT_W   = $clog2(NODES);
    localparam int CNT_W    = $clog2(NODES + 1);

    typedef enum logic {
        CMD_UPDATE = 1'b0,
        CMD_QUERY  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        REG_INCOMING     = 2'd0,
        REG_OUTGOING     = 2'd1,
        REG_LEARNER      = 2'd2,
        REG_LEARNER_VOTE = 2'd3
    } t_reg_idx;

    typedef logic [NODES-1:0] t_mask;

    typedef struct packed {
        t_mask incoming;
        t_mask outgoing;
        t_mask learner;
        logic  learners_vote;
    } t_cfg;

    typedef struct packed {
        logic start;
        logic shift;
    } t_sel_ctl;

    function automatic logic [CNT_W-1:0] popcnt(input t_mask m);
        logic [CNT_W-1:0] c;
        c = '0;
        for (int i = 0; i < NODES; i++) begin
            c = c + CNT_W'(m[i]);
        end
        return c;
    endfunction

endpackage

// ----- hdl/raftjq_plane_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raftjq_plane_mem
// bit-plane match table: word b holds bit b of every node's match index
// ----------------------------------------------------------------------------
module raftjq_plane_mem (
    input  logic                           i_clk,
    input  logic                           i_wr_en,
    input  logic [raftjq_pkg::PLANE_AW-1:0] i_wr_addr,
    input  raftjq_pkg::t_mask              i_wr_data,
    input  logic                           i_rd_en,
    input  logic [raftjq_pkg::PLANE_AW-1:0] i_rd_addr,
    output raftjq_pkg::t_mask              o_rd_data
);
    import raftjq_pkg::*;

    t_mask r_mem [VAL_W];
    t_mask r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/raftjq_select.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raftjq_select
// radix selection of the majority index of one voter set, one plane a cycle
// ----------------------------------------------------------------------------
module raftjq_select (
    input  logic                        i_clk,
    input  raftjq_pkg::t_sel_ctl        i_ctl,
    input  raftjq_pkg::t_mask           i_vset,
    input  raftjq_pkg::t_mask           i_extra,
    input  raftjq_pkg::t_mask           i_plane,
    output logic [raftjq_pkg::VAL_W-1:0] o_value,
    output logic                        o_empty
);
    import raftjq_pkg::*;

    t_mask            r_cand;
    logic [CNT_W-1:0] r_rank;
    logic [VAL_W-1:0] r_val;
    t_mask            ones;
    logic [CNT_W-1:0] c1;

    assign ones = r_cand & i_plane;
    assign c1   = popcnt(ones);

    // rank counts down from the top: position n/2 of the descending list
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_cand <= i_vset | i_extra;
            r_rank <= popcnt(i_vset) >> 1;
        end else if (i_ctl.shift) begin
            if (r_rank < c1) begin
                r_cand <= ones;
                r_val  <= {r_val[VAL_W-2:0], 1'b1};
            end else begin
                r_cand <= r_cand & ~i_plane;
                r_rank <= r_rank - c1;
                r_val  <= {r_val[VAL_W-2:0], 1'b0};
            end
        end
    end

    assign o_value = r_val;
    assign o_empty = (i_vset == '0);

endmodule

// ----- hdl/raftjq_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raftjq_regs
// apb configuration registers: voter masks, learner mask, learner counting
// ----------------------------------------------------------------------------
module raftjq_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output raftjq_pkg::t_cfg  o_cfg
);
    import raftjq_pkg::*;

    t_cfg r_cfg;
    logic wr;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr) begin
            unique case (paddr[3:2])
                REG_INCOMING:     r_cfg.incoming      <= pwdata[NODES-1:0];
                REG_OUTGOING:     r_cfg.outgoing      <= pwdata[NODES-1:0];
                REG_LEARNER:      r_cfg.learner       <= pwdata[NODES-1:0];
                REG_LEARNER_VOTE: r_cfg.learners_vote <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_INCOMING:     prdata[NODES-1:0] = r_cfg.incoming;
            REG_OUTGOING:     prdata[NODES-1:0] = r_cfg.outgoing;
            REG_LEARNER:      prdata[NODES-1:0] = r_cfg.learner;
            REG_LEARNER_VOTE: prdata[0]         = r_cfg.learners_vote;
            default: ;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hdl/raft_joint_quorum_commit_tracker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raft_joint_quorum_commit_tracker
// joint-consensus commit index and ack quorum tracker over 16 node slots
// ----------------------------------------------------------------------------
// Match indices live in a 64-word bit-plane memory (word b = bit b of every
// slot) with one read and one write port. An update rewrites all 64 planes,
// one plane a cycle, then the commit index is rebuilt by radix selection over
// the planes from the top bit down, again one plane a cycle, for the incoming
// and outgoing sets side by side. A query runs the selection pass only; an
// update runs the rewrite pass and then the selection pass. The result is
// loaded into the output register when that register is empty or is being
// read. One item is in work at a time; the next is accepted once the result
// is in the output register, even while that result waits.
// Slots that were never updated read as zero through per-slot valid bits,
// without any clearing pass.
module raft_joint_quorum_commit_tracker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [3:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_cmd,
    input  logic [raftjq_pkg::SLOT_W-1:0] i_node,
    input  logic [raftjq_pkg::VAL_W-1:0] i_match_value,
    input  logic [raftjq_pkg::NODES-1:0] i_ack_mask,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [raftjq_pkg::VAL_W-1:0] o_commit_value,
    output logic                         o_quorum_ok
);
    import raftjq_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_UPD  = 2'd1;
    localparam logic [1:0] ST_SEL  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    localparam logic [PLANE_AW-1:0] CNT_MAX = PLANE_AW'(VAL_W - 1);

    t_cfg cfg;

    logic [1:0]          r_state,  n_state;
    logic [PLANE_AW-1:0] r_cnt,    n_cnt;
    logic                r_issue,  n_issue;
    logic                r_pend,   n_pend;
    logic                r_last,   n_last;
    logic [PLANE_AW-1:0] r_paddr,  n_paddr;
    t_mask               r_valid,  n_valid;
    logic                r_out_valid, n_out_valid;
    logic [SLOT_W-1:0]   r_node,   n_node;
    logic [VAL_W-1:0]    r_mv,     n_mv;
    logic                r_ok,     n_ok;
    logic [VAL_W-1:0]    r_commit;
    logic                r_oq;

    logic                rd_en;
    logic [PLANE_AW-1:0] rd_addr;
    t_mask               mem_rd;
    logic                wr_en;
    logic [PLANE_AW-1:0] wr_addr;
    t_mask               wr_data;
    t_mask               plane;
    t_sel_ctl            sel;
    t_mask               extra_in, extra_out;
    logic [VAL_W-1:0]    val_in, val_out;
    logic                empty_in, empty_out;
    logic [VAL_W-1:0]    commit_min, commit;
    logic                in_acc, out_acc, load_out, quorum;

    function automatic logic reached(input t_mask vset, input t_mask acks,
                                     input t_cfg c);
        logic [CNT_W-1:0] hits;
        hits = popcnt(vset & acks);
        if (c.learners_vote) begin
            hits = hits + popcnt(c.learner & ~vset & acks);
        end
        return (vset == '0) || ({hits, 1'b0} > {1'b0, popcnt(vset)});
    endfunction

    raftjq_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    raftjq_plane_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (mem_rd)
    );

    // slots never written read as zero
    assign plane     = mem_rd & r_valid;
    assign extra_in  = cfg.learners_vote ? (cfg.learner & ~cfg.incoming) : '0;
    assign extra_out = cfg.learners_vote ? (cfg.learner & ~cfg.outgoing) : '0;

    raftjq_select u_sel_in (
        .i_clk   (i_clk),
        .i_ctl   (sel),
        .i_vset  (cfg.incoming),
        .i_extra (extra_in),
        .i_plane (plane),
        .o_value (val_in),
        .o_empty (empty_in)
    );

    raftjq_select u_sel_out (
        .i_clk   (i_clk),
        .i_ctl   (sel),
        .i_vset  (cfg.outgoing),
        .i_extra (extra_out),
        .i_plane (plane),
        .o_value (val_out),
        .o_empty (empty_out)
    );

    assign o_stall = (r_state != ST_IDLE);
    assign in_acc  = i_valid & ~o_stall;
    assign out_acc = r_out_valid & ~i_stall;
    assign quorum  = reached(cfg.incoming, i_ack_mask, cfg) &&
                     reached(cfg.outgoing, i_ack_mask, cfg);

    // empty set counts as all ones, all ones reports as zero
    always_comb begin
        commit_min = empty_in ? '1 : val_in;
        if (!empty_out && (val_out < commit_min)) begin
            commit_min = val_out;
        end
        commit = (commit_min == '1) ? '0 : commit_min;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_issue     = r_issue;
        n_valid     = r_valid;
        n_out_valid = r_out_valid;
        n_node      = r_node;
        n_mv        = r_mv;
        n_ok        = r_ok;
        sel         = '0;
        load_out    = 1'b0;

        rd_en   = r_issue;
        rd_addr = (r_state == ST_UPD) ? r_cnt : ~r_cnt;
        n_pend  = r_issue;
        n_last  = r_issue && (r_cnt == CNT_MAX);
        n_paddr = rd_addr;

        // write of plane a lands while plane a+1 is read: never the same word
        wr_en            = 1'b0;
        wr_addr          = r_paddr;
        wr_data          = mem_rd;
        wr_data[r_node]  = r_mv[r_paddr];

        if (r_issue) begin
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_MAX) begin
                n_issue = 1'b0;
            end
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_node  = i_node;
                    n_mv    = i_match_value;
                    n_ok    = (i_cmd == CMD_QUERY) ? quorum : 1'b0;
                    n_cnt   = '0;
                    n_issue = 1'b1;
                    if (i_cmd == CMD_UPDATE) begin
                        n_state = ST_UPD;
                    end else begin
                        n_state   = ST_SEL;
                        sel.start = 1'b1;
                    end
                end
            end
            ST_UPD: begin
                if (r_pend) begin
                    wr_en = 1'b1;
                    if (r_last) begin
                        n_valid[r_node] = 1'b1;
                        n_state         = ST_SEL;
                        n_issue         = 1'b1;
                        n_cnt           = '0;
                        sel.start       = 1'b1;
                    end
                end
            end
            ST_SEL: begin
                if (r_pend) begin
                    sel.shift = 1'b1;
                    if (r_last) begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                if (!r_out_valid || !i_stall) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (out_acc) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_issue     <= 1'b0;
            r_pend      <= 1'b0;
            r_last      <= 1'b0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_issue     <= n_issue;
            r_pend      <= n_pend;
            r_last      <= n_last;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_paddr <= n_paddr;
        r_node  <= n_node;
        r_mv    <= n_mv;
        r_ok    <= n_ok;
        if (load_out) begin
            r_commit <= commit;
            r_oq     <= r_ok;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_commit_value = r_commit;
    assign o_quorum_ok    = r_oq;

    a_no_same_word_rw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("plane read and write hit the same word");

    a_fin_after_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |-> ($past(r_state) == ST_SEL || $past(r_state) == ST_FIN))
        else $error("result stage entered without a selection pass");

    a_valid_from_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid != $past(r_valid)) |-> ($past(r_state) == ST_UPD))
        else $error("slot valid bit changed outside an update pass");

endmodule
